// File: design/policy_job_queue_assert.svh
// assertion macros used by the queue sequencer pjq_seq
`ifndef POLICY_JOB_QUEUE_ASSERT_SVH
`define POLICY_JOB_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PJQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PJQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PJQ_ASSERT(lbl, prop, msg)
`define PJQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/pjq_pkg.sv
package pjq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int WAIT_W = 20;
    localparam int KEY_W  = 16;
    localparam int QUE_W  = 5;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  job_id;
        logic [15:0] burst;
        logic [7:0]  job_priority;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        out_id;
        logic [15:0]       out_burst;
        logic [7:0]        out_priority;
        logic [QUE_W-1:0]  queued;
        logic [WAIT_W-1:0] expected_wait;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [7:0]  id;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_EMIT
    } seq_state_t;

    function automatic logic [KEY_W-1:0] entry_key(input entry_t e, input logic [1:0] pol);
        logic [KEY_W-1:0] k;
        unique case (pol)
            POL_SJF:  k = e.burst;
            POL_PRIO: k = KEY_W'(e.prio);
            default:  k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: design/policy_job_queue.sv
// channel   dir  handshake                 payload
// in        in   in_valid / in_ready       in_data (command, job_id, burst, job_priority)
// out       out  out_valid / out_ready     out_data (status, job, queued, expected_wait)
// cfg       in   cfg_wr_en, no wait        cfg_wr_data (policy)
//
// a submit is accepted with the store write, then its result is given
// a dispatch runs one key comparator walking the store over the N waiting jobs,
// then a one-slot-per-cycle compaction closes the gap left by the winner;
// a request is taken while a result still waits
// a waiting result stalls only the final step of the following request
// rst_n clears queue count, wait total, policy and handshake state; store contents are not cleared
module policy_job_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pjq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pjq_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data
);
    import pjq_pkg::*;

    logic [1:0] policy_reg, policy_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       slot_free;
    logic       res_valid;
    out_item_t  res_data;
    mem_ctl_t   mem_ctl;
    entry_t     rdata;

    assign slot_free = !out_valid_reg || out_ready;

    pjq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .policy    (policy_reg),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res_data  (res_data),
        .mem_ctl   (mem_ctl),
        .rdata     (rdata)
    );

    pjq_store u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rdata   (rdata)
    );

    always_comb
    begin
        policy_next    = cfg_wr_en ? cfg_wr_data : policy_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FCFS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            policy_reg    <= policy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/pjq_store.sv
module pjq_store (
    input  logic             clk,
    input  pjq_pkg::mem_ctl_t mem_ctl,
    output pjq_pkg::entry_t   rdata
);
    import pjq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.we)
        begin
            mem[mem_ctl.waddr] <= mem_ctl.wdata;
        end
        rdata_reg <= mem[mem_ctl.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pjq_seq.sv
`include "policy_job_queue_assert.svh"

module pjq_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pjq_pkg::in_item_t in_data,
    input  logic [1:0]        policy,
    input  logic              slot_free,
    output logic              res_valid,
    output pjq_pkg::out_item_t res_data,
    output pjq_pkg::mem_ctl_t mem_ctl,
    input  pjq_pkg::entry_t   rdata
);
    import pjq_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  sh_idx_reg, sh_idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    entry_t            best_reg, best_next;
    logic [1:0]        status_reg, status_next;

    logic [KEY_W-1:0]  cur_key;
    logic              take;
    logic              scan_last;
    logic              shift_more;
    logic              occ_full;
    logic              occ_empty;
    logic [IDX_W-1:0]  cand_idx;
    logic [KEY_W-1:0]  cand_key;
    entry_t            cand_entry;

    // one comparator shared by every step of the scan
    assign cur_key    = entry_key(rdata, policy);
    assign take       = (scan_idx_reg == '0) || (cur_key < best_key_reg);
    assign cand_idx   = take ? scan_idx_reg : best_idx_reg;
    assign cand_key   = take ? cur_key : best_key_reg;
    assign cand_entry = take ? rdata : best_reg;
    assign scan_last  = (OCC_W'(scan_idx_reg) + OCC_W'(1)) == occ_reg;
    // occ_reg already excludes the removed job here
    assign shift_more = OCC_W'(sh_idx_reg) < occ_reg;
    assign occ_full   = occ_reg >= OCC_W'(DEPTH);
    assign occ_empty  = occ_reg == '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.command == CMD_TAKE && !occ_empty)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        occ_next      = occ_reg;
        wait_next     = wait_reg;
        scan_idx_next = scan_idx_reg;
        sh_idx_next   = sh_idx_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        mem_ctl       = '0;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    best_next     = '0;
                    scan_idx_next = '0;
                    status_next   = STATUS_OK;
                    if (in_data.command == CMD_SUBMIT)
                    begin
                        if (occ_full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_ctl.we          = 1'b1;
                            mem_ctl.waddr       = IDX_W'(occ_reg);
                            mem_ctl.wdata.id    = in_data.job_id;
                            mem_ctl.wdata.burst = in_data.burst;
                            mem_ctl.wdata.prio  = in_data.job_priority;
                            occ_next            = occ_reg + OCC_W'(1);
                            wait_next           = wait_reg + WAIT_W'(in_data.burst);
                        end
                    end
                    else if (occ_empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    // read of slot 0 primes the scan
                end
            end
            ST_SCAN:
            begin
                best_idx_next = cand_idx;
                best_key_next = cand_key;
                best_next     = cand_entry;
                if (scan_last)
                begin
                    occ_next      = occ_reg - OCC_W'(1);
                    wait_next     = wait_reg - WAIT_W'(cand_entry.burst);
                    sh_idx_next   = cand_idx;
                    mem_ctl.raddr = IDX_W'(OCC_W'(cand_idx) + OCC_W'(1));
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    mem_ctl.raddr = IDX_W'(OCC_W'(scan_idx_reg) + OCC_W'(1));
                end
            end
            ST_SHIFT:
            begin
                if (shift_more)
                begin
                    // close the gap one slot per cycle
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = sh_idx_reg;
                    mem_ctl.wdata = rdata;
                    sh_idx_next   = IDX_W'(OCC_W'(sh_idx_reg) + OCC_W'(1));
                    mem_ctl.raddr = IDX_W'(OCC_W'(sh_idx_reg) + OCC_W'(2));
                end
            end
            ST_EMIT:
            begin
                res_valid = slot_free;
            end
            default: ;
        endcase
    end

    assign res_data.status        = status_reg;
    assign res_data.out_id        = best_reg.id;
    assign res_data.out_burst     = best_reg.burst;
    assign res_data.out_priority  = best_reg.prio;
    assign res_data.queued        = QUE_W'(occ_reg);
    assign res_data.expected_wait = wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        sh_idx_reg   <= sh_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
    end

    `PJQ_ASSERT(a_occ_bound, occ_reg <= OCC_W'(DEPTH), "occupancy above depth")
    `PJQ_ASSERT(a_scan_in_range, state_reg == ST_SCAN |-> OCC_W'(scan_idx_reg) < occ_reg, "scan past last job")
    `PJQ_ASSERT(a_shift_write_range, state_reg == ST_SHIFT && mem_ctl.we |-> OCC_W'(mem_ctl.waddr) < occ_reg, "compaction writes past queue")
    `PJQ_ASSERT(a_no_job_on_fail, res_valid && status_reg != STATUS_OK |-> best_reg == '0, "failed request carries a job")

endmodule
